>>> hw/rtl/qbta_pkg.sv
// types and codes shared by the queue block time accounting block
`default_nettype none

package qbta_pkg;

  typedef enum logic [1:0] {
    MODE_INIT      = 2'd0,
    MODE_BLOCKED   = 2'd1,
    MODE_UNBLOCKED = 2'd2,
    MODE_UNKNOWN   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_BLOCK   = 2'd0,
    CMD_UNBLOCK = 2'd1,
    CMD_LOST    = 2'd2,
    CMD_OTHER   = 2'd3
  } cmd_e;

  typedef struct packed {
    mode_e mode_nxt;
    logic  touch;
    logic  credit;
    logic  to_blocked;
    logic  use_pre;
    logic  set_owner;
  } ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/qbta_ctrl.sv
// mode transition and credit decision for one trace item
`default_nettype none

module qbta_ctrl (
  input  qbta_pkg::cmd_e  cmd_i,
  input  qbta_pkg::mode_e mode_i,
  input  logic            owner_hit_i,
  input  logic            pre_nonzero_i,
  output qbta_pkg::ctrl_t ctrl_o
);

  logic blk;

  always_comb begin
    blk                = (mode_i == qbta_pkg::MODE_BLOCKED);
    ctrl_o.mode_nxt    = mode_i;
    ctrl_o.touch       = 1'b0;
    ctrl_o.credit      = 1'b0;
    ctrl_o.to_blocked  = 1'b0;
    ctrl_o.use_pre     = 1'b0;
    ctrl_o.set_owner   = 1'b0;
    case (mode_i)
      qbta_pkg::MODE_INIT: begin
        if (cmd_i == qbta_pkg::CMD_BLOCK || cmd_i == qbta_pkg::CMD_UNBLOCK) begin
          ctrl_o.mode_nxt  = (cmd_i == qbta_pkg::CMD_BLOCK) ? qbta_pkg::MODE_BLOCKED
                                                              : qbta_pkg::MODE_UNBLOCKED;
          ctrl_o.set_owner = 1'b1;
          ctrl_o.touch     = 1'b1;
        end else if (cmd_i == qbta_pkg::CMD_LOST) begin
          ctrl_o.mode_nxt = qbta_pkg::MODE_UNKNOWN;
          ctrl_o.touch    = 1'b1;
        end
      end
      qbta_pkg::MODE_BLOCKED, qbta_pkg::MODE_UNBLOCKED: begin
        ctrl_o.to_blocked = blk;
        if ((cmd_i == qbta_pkg::CMD_UNBLOCK && blk) ||
            (cmd_i == qbta_pkg::CMD_BLOCK && !blk)) begin
          ctrl_o.credit   = 1'b1;
          ctrl_o.mode_nxt = blk ? qbta_pkg::MODE_UNBLOCKED : qbta_pkg::MODE_BLOCKED;
          ctrl_o.touch    = 1'b1;
        end else if (cmd_i == qbta_pkg::CMD_LOST && owner_hit_i) begin
          ctrl_o.credit   = pre_nonzero_i;
          ctrl_o.use_pre  = 1'b1;
          ctrl_o.mode_nxt = qbta_pkg::MODE_UNKNOWN;
          ctrl_o.touch    = 1'b1;
        end
      end
      qbta_pkg::MODE_UNKNOWN: begin
        if (cmd_i == qbta_pkg::CMD_BLOCK) begin
          ctrl_o.credit     = 1'b1;
          ctrl_o.to_blocked = 1'b0;
          ctrl_o.mode_nxt   = qbta_pkg::MODE_BLOCKED;
          ctrl_o.touch      = 1'b1;
        end else if (cmd_i == qbta_pkg::CMD_UNBLOCK) begin
          ctrl_o.credit     = 1'b1;
          ctrl_o.to_blocked = 1'b1;
          ctrl_o.mode_nxt   = qbta_pkg::MODE_UNBLOCKED;
          ctrl_o.touch      = 1'b1;
        end else if (cmd_i == qbta_pkg::CMD_LOST && owner_hit_i) begin
          ctrl_o.touch = 1'b1;
        end
      end
      default: begin
        ctrl_o.mode_nxt = mode_i;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/queue_block_time_accounting_top.sv
// top level of the queue block time accounting monitor
`default_nettype none

// Tracks how long a queue spends blocked and unblocked from a stream of
// timestamped trace items. One item is taken every cycle while in_stall_o
// is low. An item is held in the input register, and its result is offered
// from the result register once the item advances out of it. The running
// totals are updated by one subtract from the last timestamp followed by
// the accumulator adds, all between the input register and the result
// register. Time values wrap modulo 2^TIME_BITS; only the low CPU_BITS of
// the cpu are kept.

module queue_block_time_accounting_top #(
  parameter int TIME_BITS = 64,
  parameter int CPU_BITS  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [CPU_BITS-1:0]  event_cpu_i,
  input  logic [TIME_BITS-1:0] event_time_i,
  input  logic [TIME_BITS-1:0] pre_loss_time_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TIME_BITS-1:0] delta_time_o,
  output logic [TIME_BITS-1:0] blocked_total_o,
  output logic [TIME_BITS-1:0] unblocked_total_o,
  output logic [TIME_BITS-1:0] all_total_o,
  output logic [1:0]           queue_mode_o
);

  // input stage
  logic                 in_valid_q;
  logic [1:0]           cmd_q;
  logic [CPU_BITS-1:0]  cpu_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] pre_q;

  // accounting state
  qbta_pkg::mode_e      mode_q, mode_d;
  logic [CPU_BITS-1:0]  owner_cpu_q, owner_cpu_d;
  logic                 owner_valid_q, owner_valid_d;
  logic [TIME_BITS-1:0] last_time_q, last_time_d;
  logic [TIME_BITS-1:0] blocked_sum_q, blocked_sum_d;
  logic [TIME_BITS-1:0] unblocked_sum_q, unblocked_sum_d;
  logic [TIME_BITS-1:0] total_sum_q, total_sum_d;

  // result stage
  logic                 out_valid_q;
  logic [TIME_BITS-1:0] delta_q, delta_d;
  logic [TIME_BITS-1:0] blk_out_q, unblk_out_q, all_out_q;
  logic [1:0]           mode_out_q;

  logic                 out_free;
  logic                 advance;
  logic                 owner_hit;
  logic                 pre_nonzero;
  logic [TIME_BITS-1:0] span_end;
  logic [TIME_BITS-1:0] span;
  qbta_pkg::ctrl_t      ctrl;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  assign owner_hit   = owner_valid_q && (cpu_q == owner_cpu_q);
  assign pre_nonzero = (pre_q != '0);

  qbta_ctrl u_ctrl (
    .cmd_i         (qbta_pkg::cmd_e'(cmd_q)),
    .mode_i        (mode_q),
    .owner_hit_i   (owner_hit),
    .pre_nonzero_i (pre_nonzero),
    .ctrl_o        (ctrl)
  );

  always_comb begin
    span_end        = ctrl.use_pre ? pre_q : now_q;
    span            = span_end - last_time_q;
    delta_d         = ctrl.credit ? span : '0;
    mode_d          = ctrl.mode_nxt;
    owner_cpu_d     = ctrl.set_owner ? cpu_q : owner_cpu_q;
    owner_valid_d   = owner_valid_q || ctrl.set_owner;
    last_time_d     = ctrl.touch ? now_q : last_time_q;
    blocked_sum_d   = blocked_sum_q + (ctrl.to_blocked ? delta_d : '0);
    unblocked_sum_d = unblocked_sum_q + (ctrl.to_blocked ? '0 : delta_d);
    total_sum_d     = total_sum_q + delta_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      cmd_q <= cmd_i;
      cpu_q <= event_cpu_i;
      now_q <= event_time_i;
      pre_q <= pre_loss_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= qbta_pkg::MODE_INIT;
      owner_cpu_q     <= '0;
      owner_valid_q   <= 1'b0;
      last_time_q     <= '0;
      blocked_sum_q   <= '0;
      unblocked_sum_q <= '0;
      total_sum_q     <= '0;
    end else if (advance) begin
      mode_q          <= mode_d;
      owner_cpu_q     <= owner_cpu_d;
      owner_valid_q   <= owner_valid_d;
      last_time_q     <= last_time_d;
      blocked_sum_q   <= blocked_sum_d;
      unblocked_sum_q <= unblocked_sum_d;
      total_sum_q     <= total_sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      delta_q     <= delta_d;
      blk_out_q   <= blocked_sum_d;
      unblk_out_q <= unblocked_sum_d;
      all_out_q   <= total_sum_d;
      mode_out_q  <= mode_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign delta_time_o      = delta_q;
  assign blocked_total_o   = blk_out_q;
  assign unblocked_total_o = unblk_out_q;
  assign all_total_o       = all_out_q;
  assign queue_mode_o      = mode_out_q;

`ifndef SYNTHESIS
  a_no_owner_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == qbta_pkg::MODE_INIT) |-> !owner_valid_q)
    else $error("owner set while still in init");

  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_sum_q == TIME_BITS'(blocked_sum_q + unblocked_sum_q))
    else $error("total differs from blocked plus unblocked");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with free pipeline");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(mode_q) && $stable(total_sum_q) && $stable(last_time_q)))
    else $error("state changed without an item");
`endif

endmodule

`default_nettype wire
